>>> design/bcc_pkg.sv
package bcc_pkg;

   localparam int DEFAULT_TIME_WIDTH = 32;
   localparam int NOW_WIDTH          = 32;
   localparam int THRESH_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH    = 2;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_CLICK = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS   = 2'd2;

   localparam logic [THRESH_WIDTH-1:0] DEBOUNCE_RESET     = 16'd20;
   localparam logic [THRESH_WIDTH-1:0] DOUBLE_CLICK_RESET = 16'd300;
   localparam logic [THRESH_WIDTH-1:0] LONG_PRESS_RESET   = 16'd1000;

   typedef struct packed {
      logic                 key_level;
      logic [NOW_WIDTH-1:0] now_ms;
   } bcc_req_type;

   typedef struct packed {
      logic single_click;
      logic double_click;
      logic long_press;
   } bcc_rsp_type;

   typedef struct packed {
      logic [THRESH_WIDTH-1:0] debounce_ms;
      logic [THRESH_WIDTH-1:0] double_click_ms;
      logic [THRESH_WIDTH-1:0] long_press_ms;
   } bcc_thresh_type;

endpackage

>>> design/bcc_csr.sv
module bcc_csr
   import bcc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] wr_index,
   input  logic [THRESH_WIDTH-1:0]    wr_data,
   output bcc_thresh_type             thresh
);

   bcc_thresh_type thresh_ff;
   bcc_thresh_type thresh_in;

   always_comb begin
      thresh_in = thresh_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_DEBOUNCE:     thresh_in.debounce_ms     = wr_data;
            CSR_DOUBLE_CLICK: thresh_in.double_click_ms = wr_data;
            CSR_LONG_PRESS:   thresh_in.long_press_ms   = wr_data;
            default:          thresh_in = thresh_ff;  // index out of range, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.debounce_ms     <= DEBOUNCE_RESET;
         thresh_ff.double_click_ms <= DOUBLE_CLICK_RESET;
         thresh_ff.long_press_ms   <= LONG_PRESS_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   assign thresh = thresh_ff;

endmodule

>>> design/bcc_fsm.sv
module bcc_fsm
   import bcc_pkg::*;
#(
   parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  bcc_req_type    scan,
   input  bcc_thresh_type thresh,
   output bcc_rsp_type    event_out
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_PWAIT   = 3'd1,
      ST_PRESSED = 3'd2,
      ST_RWAIT   = 3'd3,
      ST_DWAIT   = 3'd4,
      ST_DDONE   = 3'd5,
      ST_LONG    = 3'd6
   } state_type;

   state_type             state_ff, state_in;
   logic [TIME_WIDTH-1:0] mark_ff, mark_in;
   logic [TIME_WIDTH-1:0] press_ff, press_in;
   bcc_rsp_type           event_ff, event_in;

   logic                  pressed;
   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] since_mark;
   logic [TIME_WIDTH-1:0] since_press;
   logic                  debounce_met;
   logic                  window_met;
   logic                  hold_met;

   assign pressed = ~scan.key_level;
   // timestamp truncated or zero-extended to the internal time width
   assign now = TIME_WIDTH'(scan.now_ms);

   // wrapping differences
   assign since_mark  = now - mark_ff;
   assign since_press = now - press_ff;

   assign debounce_met = since_mark  >= TIME_WIDTH'(thresh.debounce_ms);
   assign window_met   = since_mark  >= TIME_WIDTH'(thresh.double_click_ms);
   assign hold_met     = since_press >= TIME_WIDTH'(thresh.long_press_ms);

   always_comb begin
      state_in = state_ff;
      mark_in  = mark_ff;
      press_in = press_ff;
      event_in = '0;
      unique case (state_ff)
         ST_PWAIT: begin
            if (pressed) begin
               if (debounce_met) begin
                  press_in = now;
                  state_in = ST_PRESSED;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PRESSED: begin
            if (!pressed) begin
               state_in = ST_RWAIT;
               mark_in  = now;
            end else if (hold_met) begin
               event_in.long_press = 1'b1;
               state_in            = ST_LONG;
               mark_in             = now;
            end
         end
         ST_RWAIT: begin
            if (!pressed) begin
               if (debounce_met) begin
                  state_in = ST_DWAIT;
                  mark_in  = now;
               end
            end else begin
               // bounce, restart press debounce
               state_in = ST_PWAIT;
               mark_in  = now;
            end
         end
         ST_DWAIT: begin
            if (pressed) begin
               if (debounce_met) begin
                  event_in.double_click = 1'b1;
                  state_in              = ST_DDONE;
                  mark_in               = now;
               end
            end else if (window_met) begin
               event_in.single_click = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         ST_DDONE, ST_LONG: begin
            if (!pressed) begin
               if (debounce_met) begin
                  state_in = ST_IDLE;
               end
            end else begin
               mark_in = now;
            end
         end
         default: begin
            // idle and the unused code
            if (pressed) begin
               state_in = ST_PWAIT;
               mark_in  = now;
            end else begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mark_ff  <= '0;
         press_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
         mark_ff  <= mark_in;
         press_ff <= press_in;
         event_ff <= event_in;
      end
   end

   assign event_out = event_ff;

endmodule

>>> design/button_click_classifier.sv
// a scan accepted into the input register moves on when the result register is free
// throughput: one scan per cycle unless the output stalls, one state update per scan
// reset (synchronous, active high): state idle, both timestamps zero,
// thresholds 20 / 300 / 1000 ms, both pipeline stages empty
module button_click_classifier
   import bcc_pkg::*;
#(
   parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  bcc_req_type                req_data,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bcc_rsp_type                rsp_data,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [THRESH_WIDTH-1:0]    csr_data
);

   bcc_thresh_type thresh;

   logic        in_valid_ff, in_valid_in;
   bcc_req_type in_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   logic out_free;
   logic accept;
   logic step;

   assign csr_ready = 1'b1;

   bcc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .thresh   (thresh)
   );

   // result register frees when empty or its beat is taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   bcc_fsm #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .scan      (in_data_ff),
      .thresh    (thresh),
      .event_out (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_data.single_click, rsp_data.double_click,
                                rsp_data.long_press}) <= 1)
      else $error("more than one event in a result beat");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_stall |=> rsp_valid)
      else $error("held scan did not reach the result register");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("stall raised with empty input register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !in_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
